/* rtl/core/fcd_pkg.sv */
// shared types, constants and helpers for the fifo cache directory store
`timescale 1ns / 1ps

package fcd_pkg;

    localparam int NODE_W      = 16;
    localparam int NODE_DEPTH  = 65536;
    localparam int NODE_IDX_W  = $clog2(NODE_DEPTH);
    localparam int SLOT_DEPTH  = 4096;
    localparam int SLOT_W      = $clog2(SLOT_DEPTH);
    localparam int CFG_W       = 13;
    localparam int IN_DATA_W   = 16;
    localparam int OUT_DATA_W  = 32;
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

    localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(SLOT_DEPTH);

    typedef struct packed {
        logic              valid;
        logic [NODE_W-1:0] node_id;
    } fcd_item_t;

    typedef struct packed {
        logic [NODE_W-1:0] evicted_node;
        logic              evicted_valid;
        logic              was_cached;
        logic [SLOT_W-1:0] slot;
    } fcd_result_t;

    // ring advance: zero acts as one, counts above the ring size saturate
    function automatic logic [SLOT_W-1:0] slot_advance(
        input logic [SLOT_W-1:0] wp,
        input logic [CFG_W-1:0]  used
    );
        logic [SLOT_W:0] lim;
        logic [SLOT_W:0] nxt;
        if (used == '0) begin
            lim = (SLOT_W+1)'(1);
        end else if ((SLOT_W+1)'(used) > (SLOT_W+1)'(SLOT_DEPTH) ||
                     used > CFG_W'(SLOT_DEPTH)) begin
            lim = (SLOT_W+1)'(SLOT_DEPTH);
        end else begin
            lim = (SLOT_W+1)'(used);
        end
        nxt = {1'b0, wp} + (SLOT_W+1)'(1);
        if (nxt >= lim) begin
            return '0;
        end
        return nxt[SLOT_W-1:0];
    endfunction

endpackage

/* rtl/core/fcd_in_queue.sv */
// front end: accepts node beats into a short queue ahead of the map engine
`timescale 1ns / 1ps

module fcd_in_queue
    import fcd_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 enable,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [NODE_W-1:0]    s_node_id,
    output fcd_item_t            head,
    input  logic                 pop
);

    logic [NODE_W-1:0]      entry_reg [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_CNT_W-1:0] count_reg, count_next;
    logic                   push;
    logic                   do_pop;

    assign s_ready = enable && (count_reg != QUEUE_CNT_W'(QUEUE_DEPTH));
    assign push    = s_valid && s_ready;
    assign do_pop  = pop && (count_reg != '0);

    assign head.valid   = (count_reg != '0);
    assign head.node_id = entry_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0
                          : wr_ptr_reg + QUEUE_PTR_W'(1);
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0
                          : rd_ptr_reg + QUEUE_PTR_W'(1);
        end
        if (push && !do_pop) begin
            count_next = count_reg + QUEUE_CNT_W'(1);
        end else if (do_pop && !push) begin
            count_next = count_reg - QUEUE_CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= s_node_id;
        end
    end

endmodule

/* rtl/core/fcd_map_engine.sv */
// back end: node and slot map memories, read-evaluate-commit sequencer
`timescale 1ns / 1ps

module fcd_map_engine
    import fcd_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_wr_en,
    input  logic [CFG_W-1:0]   cfg_wr_data,
    input  fcd_item_t          head,
    output logic               pop,
    output logic               init_done,
    output logic               m_valid,
    input  logic               m_ready,
    output fcd_result_t        m_result
);

    localparam logic [1:0] ST_CLEAR  = 2'd0;
    localparam logic [1:0] ST_IDLE   = 2'd1;
    localparam logic [1:0] ST_EVAL   = 2'd2;
    localparam logic [1:0] ST_COMMIT = 2'd3;

    // node map word: {present, slot}; slot map word: {present, node}
    logic [SLOT_W:0] node_mem [NODE_DEPTH];
    logic [NODE_W:0] slot_mem [SLOT_DEPTH];

    logic [1:0]            state_reg, state_next;
    logic [NODE_IDX_W-1:0] clr_cnt_reg;
    logic [CFG_W-1:0]      slots_used_reg;
    logic [SLOT_W-1:0]     wp_reg;
    logic [SLOT_W:0]       fill_reg;
    logic [NODE_W-1:0]     id_reg;
    logic [SLOT_W:0]       node_rd_reg;
    logic [NODE_W:0]       slot_rd_reg;
    logic                  slot_written_reg;
    fcd_result_t           res_reg;
    logic                  m_valid_reg, m_valid_next;
    fcd_result_t           m_result_reg;

    logic                  node_re, node_we;
    logic [NODE_IDX_W-1:0] node_ra, node_wa;
    logic [SLOT_W:0]       node_wd;
    logic                  slot_re, slot_we;
    logic [SLOT_W-1:0]     slot_wa;
    logic [NODE_W:0]       slot_wd;

    logic                  was_cached;
    logic [SLOT_W-1:0]     old_slot;
    logic                  ev_valid;
    logic                  out_free;
    logic                  commit;

    assign init_done = (state_reg != ST_CLEAR);
    assign out_free  = !m_valid_reg || m_ready;
    assign commit    = (state_reg == ST_COMMIT) && out_free;
    assign pop       = (state_reg == ST_IDLE) && head.valid;

    // taken slot loses its node unless it was the node's own old slot
    assign was_cached = node_rd_reg[SLOT_W];
    assign old_slot   = node_rd_reg[SLOT_W-1:0];
    assign ev_valid   = slot_written_reg && slot_rd_reg[NODE_W] &&
                        !(was_cached && (old_slot == wp_reg));

    always_comb begin
        state_next = state_reg;
        node_re = 1'b0;
        node_ra = head.node_id[NODE_IDX_W-1:0];
        node_we = 1'b0;
        node_wa = clr_cnt_reg;
        node_wd = '0;
        slot_re = 1'b0;
        slot_we = 1'b0;
        slot_wa = old_slot;
        slot_wd = '0;
        unique case (state_reg)
            ST_CLEAR: begin
                node_we = 1'b1;
                if (clr_cnt_reg == '1) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (head.valid) begin
                    node_re    = 1'b1;
                    slot_re    = 1'b1;
                    state_next = ST_EVAL;
                end
            end
            ST_EVAL: begin
                slot_we    = was_cached;
                node_we    = ev_valid;
                node_wa    = slot_rd_reg[NODE_IDX_W-1:0];
                state_next = ST_COMMIT;
            end
            ST_COMMIT: begin
                if (out_free) begin
                    slot_we    = 1'b1;
                    slot_wa    = wp_reg;
                    slot_wd    = {1'b1, id_reg};
                    node_we    = 1'b1;
                    node_wa    = id_reg[NODE_IDX_W-1:0];
                    node_wd    = {1'b1, wp_reg};
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_CLEAR;
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (commit) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_CLEAR;
            clr_cnt_reg    <= '0;
            slots_used_reg <= CFG_RESET;
            wp_reg         <= '0;
            fill_reg       <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            if (state_reg == ST_CLEAR) begin
                clr_cnt_reg <= clr_cnt_reg + NODE_IDX_W'(1);
            end
            if (cfg_wr_en) begin
                slots_used_reg <= cfg_wr_data;
            end
            if (commit) begin
                wp_reg <= slot_advance(wp_reg, slots_used_reg);
                if ({1'b0, wp_reg} == fill_reg) begin
                    fill_reg <= fill_reg + (SLOT_W+1)'(1);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (node_we) begin
            node_mem[node_wa] <= node_wd;
        end
        if (node_re) begin
            node_rd_reg <= node_mem[node_ra];
        end
    end

    always_ff @(posedge aclk) begin
        if (slot_we) begin
            slot_mem[slot_wa] <= slot_wd;
        end
        if (slot_re) begin
            slot_rd_reg <= slot_mem[wp_reg];
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            id_reg           <= head.node_id;
            slot_written_reg <= ({1'b0, wp_reg} < fill_reg);
        end
        if (state_reg == ST_EVAL) begin
            res_reg.slot          <= wp_reg;
            res_reg.was_cached    <= was_cached;
            res_reg.evicted_valid <= ev_valid;
            res_reg.evicted_node  <= ev_valid ? slot_rd_reg[NODE_W-1:0] : '0;
        end
        if (commit) begin
            m_result_reg <= res_reg;
        end
    end

    assign m_valid  = m_valid_reg;
    assign m_result = m_result_reg;

endmodule

/* rtl/core/fifo_cache_directory_store.sv */
// top level of the fifo cache directory store
//
//  channel   dir  handshake                      payload
//  s_axis    in   s_axis_tvalid / s_axis_tready  node_id
//  m_axis    out  m_axis_tvalid / m_axis_tready  slot, was_cached, evicted_valid, evicted_node
//  cfg       in   cfg_wr_en                      cache_slots_used
//
// each item goes through the steps read both maps, evaluate and invalidate, commit,
// in order; a new item is taken only after commit, as each map memory has a single write port
// after reset a clearing pass writes all 65536 node map entries, with
// s_axis_tready low; configuration writes are taken during it
// a two-beat input queue keeps accepting while the engine works or the
// result register waits on m_axis_tready; a stalled result holds the commit
`timescale 1ns / 1ps

module fifo_cache_directory_store
    import fcd_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [CFG_W-1:0]      cfg_wr_data,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,  // [15:0] node_id
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // [11:0] slot, [12] was_cached, [13] evicted_valid, [29:14] evicted_node, [31:30] zero
    output logic [OUT_DATA_W-1:0] m_axis_tdata
);

    localparam int RES_W = $bits(fcd_result_t);

    fcd_item_t   head;
    fcd_result_t result;
    logic        pop;
    logic        init_done;

    fcd_in_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .enable    (init_done),
        .s_valid   (s_axis_tvalid),
        .s_ready   (s_axis_tready),
        .s_node_id (s_axis_tdata[NODE_W-1:0]),
        .head      (head),
        .pop       (pop)
    );

    fcd_map_engine u_engine (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .head        (head),
        .pop         (pop),
        .init_done   (init_done),
        .m_valid     (m_axis_tvalid),
        .m_ready     (m_axis_tready),
        .m_result    (result)
    );

    assign m_axis_tdata = {(OUT_DATA_W - RES_W)'(0), result};

endmodule

/* rtl/core/fcd_checker.sv */
// port-level checks for the fifo cache directory store, bound to the top level
`timescale 1ns / 1ps

module fcd_checker
    import fcd_pkg::*;
(
    input logic                  aclk,
    input logic                  aresetn,
    input logic                  s_axis_tready,
    input logic                  m_axis_tvalid,
    input logic                  m_axis_tready,
    input logic [OUT_DATA_W-1:0] m_axis_tdata
);

    // clearing pass keeps the input closed right after reset
    a_clear_closed: assert property (@(posedge aclk)
        !aresetn |=> !s_axis_tready)
        else $error("input open during node map clearing");

    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_axis_tvalid)
        else $error("result valid after reset");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result changed");

    // no evicted node reported without an eviction
    a_evict_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tdata[13] |-> m_axis_tdata[29:14] == '0)
        else $error("evicted node without eviction");

endmodule

bind fifo_cache_directory_store fcd_checker u_fcd_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
